/* src/lowest_free_id_allocator_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the lowest free id allocator
// Shared wrappers for the concurrent checks at the top level.
// ---------------------------------------------------------------------------
`ifndef LOWEST_FREE_ID_ALLOCATOR_MACROS_SVH
`define LOWEST_FREE_ID_ALLOCATOR_MACROS_SVH

// check a consequent in the same cycle as its trigger
`define LFID_ASSERT_SAME(label, clk, rst, trig, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
      else $error(msg);

// check a consequent in the cycle after its trigger
`define LFID_ASSERT_NEXT(label, clk, rst, trig, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error(msg);

`endif

/* src/lfid_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lfid_pkg
// Widths, codes and shared types of the lowest free id allocator.
// ---------------------------------------------------------------------------
package lfid_pkg;

   localparam int MAX_IDS       = 1024;
   localparam int MAP_WORD_BITS = 64;
   localparam int MAP_WORDS     = MAX_IDS / MAP_WORD_BITS;
   localparam int ID_W          = 10;
   localparam int MARK_W        = 11;
   localparam int STEP_W        = 7;
   localparam int OP_W          = 3;
   localparam int STATUS_W      = 2;
   localparam int WIDX_W        = $clog2(MAP_WORDS);
   localparam int BIT_W         = $clog2(MAP_WORD_BITS);

   typedef logic [ID_W-1:0]          id_type;
   typedef logic [MARK_W-1:0]        mark_type;
   typedef logic [STEP_W-1:0]        step_type;
   typedef logic [OP_W-1:0]          op_type;
   typedef logic [STATUS_W-1:0]      status_type;
   typedef logic [MAP_WORD_BITS-1:0] word_type;
   typedef logic [WIDX_W-1:0]        widx_type;
   typedef logic [BIT_W-1:0]         bidx_type;

   localparam mark_type MARK_LIMIT = mark_type'(MAX_IDS);
   localparam mark_type MARK_RESET = mark_type'(1);
   localparam step_type STEP_RESET = step_type'(10);

   // operation codes
   localparam op_type OP_ALLOCATE = 3'd0;
   localparam op_type OP_CLAIM    = 3'd1;
   localparam op_type OP_RELEASE  = 3'd2;
   localparam op_type OP_QUERY    = 3'd3;
   localparam op_type OP_CLEAR    = 3'd4;

   // status codes
   localparam status_type ST_OK          = 2'd0;
   localparam status_type ST_EXHAUSTED   = 2'd1;
   localparam status_type ST_BAD_RELEASE = 2'd2;

   // bitmap storage command
   typedef struct packed {
      logic     wr_en;
      logic     clear;
      widx_type addr;
      widx_type rd_addr;
   } map_cmd_type;

   // word unit command
   typedef struct packed {
      logic     take_low;
      mark_type lo;
      mark_type hi;
      logic     clr_en;
      id_type   clr_id;
      bidx_type test_bit;
   } word_cmd_type;

   // word unit result
   typedef struct packed {
      logic     nonzero;
      bidx_type low_bit;
      logic     test_set;
      word_type new_word;
   } word_res_type;

endpackage

/* src/lfid_map.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lfid_map
// Free bitmap storage: one word per row, a valid bit per row so that an
// unwritten or cleared row reads as empty. The read is registered: the row
// addressed by rd_addr shows up on rd_word in the next cycle.
// ---------------------------------------------------------------------------
module lfid_map import lfid_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  map_cmd_type cmd,
   input  word_type    wr_word,
   output word_type    rd_word
);

   word_type               words_ff [MAP_WORDS];
   logic [MAP_WORDS-1:0]   valid_ff;
   word_type               rd_word_ff;

   // read the requested row, empty when not valid
   always_ff @(posedge clock) begin
      rd_word_ff <= valid_ff[cmd.rd_addr] ? words_ff[cmd.rd_addr] : '0;
   end

   assign rd_word = rd_word_ff;

   // drop all rows on clear, otherwise mark written rows valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.clear) begin
         valid_ff <= '0;
      end else if (cmd.wr_en) begin
         valid_ff[cmd.addr] <= 1'b1;
      end
   end

   // store row data
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         words_ff[cmd.addr] <= wr_word;
      end
   end

endmodule

/* src/lfid_word_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lfid_word_unit
// Shared word unit: finds the lowest set bit of a bitmap word and builds the
// new word: that bit cleared, or a set range and a single cleared bit.
// ---------------------------------------------------------------------------
module lfid_word_unit import lfid_pkg::*; (
   input  widx_type     widx,
   input  word_type     word,
   input  word_cmd_type cmd,
   output word_res_type res
);

   localparam mark_type WORD_SPAN = mark_type'(MAP_WORD_BITS);

   word_type iso;
   word_type lo_mask;
   word_type hi_mask;
   word_type clr_mask;
   mark_type base;
   mark_type lo_rel;
   mark_type hi_rel;
   bidx_type low_bit;

   // isolate the lowest set bit
   assign iso = word & (~word + word_type'(1));

   // encode the isolated bit
   always_comb begin
      low_bit = '0;
      for (int i = 0; i < MAP_WORD_BITS; i++) begin
         if (iso[i]) begin
            low_bit = low_bit | bidx_type'(i);
         end
      end
   end

   // range masks relative to the first id of this word
   assign base   = mark_type'({widx, bidx_type'(0)});
   assign lo_rel = cmd.lo - base;
   assign hi_rel = cmd.hi - base;

   always_comb begin
      if (cmd.lo <= base) begin
         lo_mask = '1;
      end else if (lo_rel >= WORD_SPAN) begin
         lo_mask = '0;
      end else begin
         lo_mask = word_type'('1) << lo_rel[BIT_W-1:0];
      end
      if (cmd.hi <= base) begin
         hi_mask = '0;
      end else if (hi_rel >= WORD_SPAN) begin
         hi_mask = '1;
      end else begin
         hi_mask = ~(word_type'('1) << hi_rel[BIT_W-1:0]);
      end
   end

   // single bit to take out of the pool
   assign clr_mask = (cmd.clr_en && (cmd.clr_id[ID_W-1 -: WIDX_W] == widx))
                   ? (word_type'(1) << cmd.clr_id[BIT_W-1:0]) : '0;

   // assemble result
   always_comb begin
      res.nonzero  = (word != '0);
      res.low_bit  = low_bit;
      res.test_set = word[cmd.test_bit];
      if (cmd.take_low) begin
         res.new_word = word & ~iso;
      end else begin
         res.new_word = (word | (lo_mask & hi_mask)) & ~clr_mask;
      end
   end

endmodule

/* src/lfid_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lfid_ctrl
// Sequencer: decodes a transaction, scans or rewrites bitmap words one per
// cycle through the word unit, keeps the high mark and holds the response.
// ---------------------------------------------------------------------------
module lfid_ctrl import lfid_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  op_type       req_operation,
   input  id_type       req_id,
   input  step_type     grow_step,
   output map_cmd_type  map_cmd,
   output word_cmd_type word_cmd,
   input  word_res_type word_res,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output id_type       rsp_result_id,
   output logic         rsp_in_use,
   output status_type   rsp_status
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_WRITE  = 3'd3;
   localparam logic [2:0] S_QUERY  = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   localparam widx_type LAST_WORD = widx_type'(MAP_WORDS - 1);

   logic [2:0] state_ff, state_in;
   op_type     op_ff, op_in;
   id_type     id_ff, id_in;
   mark_type   mark_ff, mark_in;
   widx_type   widx_ff, widx_in;
   widx_type   last_ff, last_in;
   mark_type   lo_ff, lo_in;
   mark_type   hi_ff, hi_in;
   logic       clr_en_ff, clr_en_in;
   id_type     clr_id_ff, clr_id_in;
   id_type     rid_ff, rid_in;
   logic       used_ff, used_in;
   status_type status_ff, status_in;
   logic       rsp_valid_ff, rsp_valid_in;
   id_type     rsp_rid_ff, rsp_rid_in;
   logic       rsp_used_ff, rsp_used_in;
   status_type rsp_status_ff, rsp_status_in;

   mark_type   id_ext;
   mark_type   grown_mark;
   mark_type   grow_lo;
   mark_type   grow_last;
   logic       take_low;

   assign id_ext     = mark_type'(id_ff);
   assign grown_mark = mark_ff + mark_type'(grow_step);
   assign grow_lo    = mark_ff + mark_type'(1);
   assign grow_last  = grown_mark - mark_type'(1);

   // drive the shared word unit
   always_comb begin
      word_cmd.take_low = take_low;
      word_cmd.lo       = lo_ff;
      word_cmd.hi       = hi_ff;
      word_cmd.clr_en   = clr_en_ff;
      word_cmd.clr_id   = clr_id_ff;
      word_cmd.test_bit = id_ff[BIT_W-1:0];
   end

   // sequence one transaction
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      mark_in       = mark_ff;
      widx_in       = widx_ff;
      last_in       = last_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      clr_en_in     = clr_en_ff;
      clr_id_in     = clr_id_ff;
      rid_in        = rid_ff;
      used_in       = used_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_rid_in    = rsp_rid_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_status_in = rsp_status_ff;
      req_ready     = 1'b0;
      take_low      = 1'b0;
      map_cmd.wr_en = 1'b0;
      map_cmd.clear = 1'b0;
      map_cmd.addr  = widx_ff;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in     = req_operation;
               id_in     = req_id;
               rid_in    = req_id;
               used_in   = 1'b0;
               status_in = ST_OK;
               state_in  = S_DECODE;
            end
         end

         S_DECODE: begin
            case (op_ff)
               OP_ALLOCATE: begin
                  widx_in  = '0;
                  state_in = S_SCAN;
               end
               OP_CLAIM: begin
                  if (id_ff == '0) begin
                     widx_in  = '0;
                     state_in = S_SCAN;
                  end else begin
                     // pool the ids up to the claimed one, then take it
                     if (id_ext >= mark_ff) begin
                        lo_in   = mark_ff;
                        hi_in   = id_ext;
                        mark_in = id_ext + mark_type'(1);
                        widx_in = mark_ff[BIT_W +: WIDX_W];
                     end else begin
                        lo_in   = '0;
                        hi_in   = '0;
                        widx_in = id_ff[ID_W-1 -: WIDX_W];
                     end
                     clr_en_in = 1'b1;
                     clr_id_in = id_ff;
                     last_in   = id_ff[ID_W-1 -: WIDX_W];
                     state_in  = S_WRITE;
                  end
               end
               OP_RELEASE: begin
                  if (id_ff == '0 || id_ext >= mark_ff) begin
                     status_in = ST_BAD_RELEASE;
                     state_in  = S_DONE;
                  end else begin
                     lo_in     = id_ext;
                     hi_in     = id_ext + mark_type'(1);
                     clr_en_in = 1'b0;
                     widx_in   = id_ff[ID_W-1 -: WIDX_W];
                     last_in   = id_ff[ID_W-1 -: WIDX_W];
                     state_in  = S_WRITE;
                  end
               end
               OP_QUERY: begin
                  if (id_ff == '0) begin
                     used_in  = 1'b1;
                     state_in = S_DONE;
                  end else if (id_ext >= mark_ff) begin
                     state_in = S_DONE;
                  end else begin
                     widx_in  = id_ff[ID_W-1 -: WIDX_W];
                     state_in = S_QUERY;
                  end
               end
               OP_CLEAR: begin
                  map_cmd.clear = 1'b1;
                  state_in      = S_DONE;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         S_SCAN: begin
            take_low = 1'b1;
            if (word_res.nonzero) begin
               // hand out the lowest pooled id of this word
               map_cmd.wr_en = 1'b1;
               rid_in        = {widx_ff, word_res.low_bit};
               state_in      = S_DONE;
            end else if (widx_ff == LAST_WORD) begin
               // pool empty: grow the mark and hand out its old value, or report exhaustion
               if (grow_step == '0 || grown_mark > MARK_LIMIT) begin
                  status_in = ST_EXHAUSTED;
                  state_in  = S_DONE;
               end else begin
                  rid_in    = mark_ff[ID_W-1:0];
                  mark_in   = grown_mark;
                  lo_in     = grow_lo;
                  hi_in     = grown_mark;
                  clr_en_in = 1'b0;
                  widx_in   = grow_lo[BIT_W +: WIDX_W];
                  last_in   = grow_last[BIT_W +: WIDX_W];
                  if (grow_lo < grown_mark) begin
                     state_in = S_WRITE;
                  end else begin
                     state_in = S_DONE;
                  end
               end
            end else begin
               widx_in = widx_ff + widx_type'(1);
            end
         end

         S_WRITE: begin
            map_cmd.wr_en = 1'b1;
            if (widx_ff == last_ff) begin
               state_in = S_DONE;
            end else begin
               widx_in = widx_ff + widx_type'(1);
            end
         end

         S_QUERY: begin
            used_in  = ~word_res.test_set;
            state_in = S_DONE;
         end

         S_DONE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_rid_in    = rid_ff;
               rsp_used_in   = used_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // fetch the word that the next cycle works on
      map_cmd.rd_addr = widx_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mark_ff      <= MARK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mark_ff      <= mark_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      widx_ff       <= widx_in;
      last_ff       <= last_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      clr_en_ff     <= clr_en_in;
      clr_id_ff     <= clr_id_in;
      rid_ff        <= rid_in;
      used_ff       <= used_in;
      status_ff     <= status_in;
      rsp_rid_ff    <= rsp_rid_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_result_id = rsp_rid_ff;
   assign rsp_in_use    = rsp_used_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

/* src/lowest_free_id_allocator.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lowest_free_id_allocator
// Hands out the lowest free id from a word-organized free bitmap, growing
// a high mark when the pool runs dry; also claims, releases, queries and clears.
// ---------------------------------------------------------------------------
//   Channel  Ports                                   Direction
//   req      req_valid/ready, operation, id          in
//   rsp      rsp_valid/ready, result_id, in_use,     out
//            status
//   csr      csr_wr_en, csr_wr_data (grow_step)      in
//
// One transaction at a time: accept, decode, then one bitmap word per cycle
// through the shared word unit, then into the response register. Allocate
// scans up to 16 words, plus up to 3 fill words when the mark grows. Claim
// above the mark rewrites up to 16 words. The response register lets the
// next request be taken while a response waits. No clearing pass at reset.
// ---------------------------------------------------------------------------
`include "lowest_free_id_allocator_macros.svh"

module lowest_free_id_allocator import lfid_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  op_type     req_operation,
   input  id_type     req_id,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output id_type     rsp_result_id,
   output logic       rsp_in_use,
   output status_type rsp_status,
   input  logic       csr_wr_en,
   input  step_type   csr_wr_data
);

   step_type     grow_step_ff;
   map_cmd_type  map_cmd;
   word_cmd_type word_cmd;
   word_res_type word_res;
   word_type     rd_word;

   // grow step register
   always_ff @(posedge clock) begin
      if (reset) begin
         grow_step_ff <= STEP_RESET;
      end else if (csr_wr_en) begin
         grow_step_ff <= csr_wr_data;
      end
   end

   lfid_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_id        (req_id),
      .grow_step     (grow_step_ff),
      .map_cmd       (map_cmd),
      .word_cmd      (word_cmd),
      .word_res      (word_res),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_result_id (rsp_result_id),
      .rsp_in_use    (rsp_in_use),
      .rsp_status    (rsp_status)
   );

   lfid_map u_map (
      .clock   (clock),
      .reset   (reset),
      .cmd     (map_cmd),
      .wr_word (word_res.new_word),
      .rd_word (rd_word)
   );

   lfid_word_unit u_word (
      .widx (map_cmd.addr),
      .word (rd_word),
      .cmd  (word_cmd),
      .res  (word_res)
   );

   // not ready in the cycle after a request is taken
   `LFID_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "ready stayed high after accept")
   // only defined status codes leave the block
   `LFID_ASSERT_SAME(a_status_code, clock, reset, rsp_valid, rsp_status == ST_OK || rsp_status == ST_EXHAUSTED || rsp_status == ST_BAD_RELEASE, "undefined status code")
   // an in-use answer only comes with an ok status
   `LFID_ASSERT_SAME(a_in_use_ok, clock, reset, rsp_valid && rsp_in_use, rsp_status == ST_OK, "in_use with error status")

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lowest free id allocator. A bit-level model of
// the pool and the high mark predicts every response. Directed cases come
// first, then a long response stall, random traffic under several grow
// steps, and a run with the id space fully grown.
// ---------------------------------------------------------------------------
module tb_top;
   import lfid_pkg::*;

   // spare operation codes; the block answers them without touching state
   localparam op_type OP_SPARE_FIRST = 3'd5;
   localparam op_type OP_SPARE_LAST  = 3'd7;
   localparam int     ID_TOP         = MAX_IDS - 1;
   localparam int     DRAIN_PAD      = 30;
   localparam int     QUIET_LIMIT    = 2000;
   localparam int     LONG_HOLD      = 300;

   typedef struct packed {
      id_type     result_id;
      logic       in_use;
      status_type status;
   } grant_reply_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   op_type     req_operation = OP_QUERY;
   id_type     req_id = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   id_type     rsp_result_id;
   logic       rsp_in_use;
   status_type rsp_status;
   logic       csr_wr_en = 1'b0;
   step_type   csr_wr_data = '0;

   // model of the allocator state
   logic [MAX_IDS-1:0] pool_model = '0;
   int                 mark_model = 1;
   int                 grow_step_model = 10;

   grant_reply_type expected_replies[$];
   id_type          held_ids[$];
   int              mismatches = 0;
   int              hold_off_cycles = 0;
   int              quiet_cycles = 0;
   bit              steady = 1'b0;

   always #4 clock = ~clock;

   lowest_free_id_allocator DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_id        (req_id),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_result_id (rsp_result_id),
      .rsp_in_use    (rsp_in_use),
      .rsp_status    (rsp_status),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   // ------------------------------------------------------------------
   // Pool model
   // ------------------------------------------------------------------

   // raise the mark and pool the newly covered ids; refuse past the id space
   function automatic bit grow_pool(int new_mark);
      if (new_mark <= mark_model)
         return 1'b1;
      if (new_mark > MAX_IDS)
         return 1'b0;
      for (int v = mark_model; v < new_mark; v++)
         pool_model[v] = 1'b1;
      mark_model = new_mark;
      return 1'b1;
   endfunction

   // hand out the lowest pooled id, growing first when the pool is dry
   function automatic grant_reply_type take_lowest(grant_reply_type r);
      int low;
      low = -1;
      if (pool_model == '0) begin
         if (!grow_pool(mark_model + grow_step_model)) begin
            r.status = ST_EXHAUSTED;
            return r;
         end
      end
      for (int v = 0; v < MAX_IDS && low < 0; v++)
         if (pool_model[v])
            low = v;
      if (low < 0) begin
         r.status = ST_EXHAUSTED;
      end else begin
         pool_model[low] = 1'b0;
         r.result_id = id_type'(low);
      end
      return r;
   endfunction

   // work out the response to one transaction and advance the model
   function automatic grant_reply_type predict_grant(op_type op, id_type id);
      grant_reply_type r;
      r.result_id = id;
      r.in_use    = 1'b0;
      r.status    = ST_OK;
      case (op)
         OP_ALLOCATE: begin
            r = take_lowest(r);
         end
         OP_CLAIM: begin
            if (id == 0) begin
               r = take_lowest(r);
            end else if (id >= mark_model && !grow_pool(int'(id) + 1)) begin
               r.status = ST_EXHAUSTED;
            end else begin
               pool_model[id] = 1'b0;
            end
         end
         OP_RELEASE: begin
            if (id == 0 || id >= mark_model)
               r.status = ST_BAD_RELEASE;
            else
               pool_model[id] = 1'b1;
         end
         OP_QUERY: begin
            if (id == 0)
               r.in_use = 1'b1;
            else if (id >= mark_model)
               r.in_use = 1'b0;
            else
               r.in_use = ~pool_model[id];
         end
         OP_CLEAR: begin
            pool_model = '0;
         end
         default: ;
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // offer one transaction, hold it until taken, then record its response
   task automatic send_item(op_type op, id_type id);
      int              gap;
      grant_reply_type want;
      gap = steady ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_id        <= id;
      do @(posedge clock); while (!(req_valid && req_ready));
      want = predict_grant(op, id);
      expected_replies.insert(expected_replies.size(), want);
      if ((op == OP_ALLOCATE || op == OP_CLAIM) && want.status == ST_OK
          && want.result_id != 0)
         held_ids.insert(held_ids.size(), want.result_id);
   endtask

   // drop valid and let every outstanding response come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   task automatic write_grow_step(step_type value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      grow_step_model = int'(value);
   endtask

   // id up to 8 past the mark unless full_range, so most transactions hit live state
   function automatic id_type pick_id(bit full_range);
      int top;
      top = (mark_model + 8 > ID_TOP) ? ID_TOP : mark_model + 8;
      if (full_range)
         return id_type'($urandom_range(0, ID_TOP));
      return id_type'($urandom_range(0, top));
   endfunction

   // mostly allocates, releases and queries on live ids, with some noise mixed in
   task automatic random_items(int count, bit full_range);
      int     roll;
      int     pick;
      op_type op;
      id_type id;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         id   = id_type'($urandom_range(0, ID_TOP));
         if (roll < 30) begin
            op = OP_ALLOCATE;
         end else if (roll < 42) begin
            op = OP_CLAIM;
            if (roll >= 34)
               id = pick_id(full_range);
            else
               id = '0;
         end else if (roll < 65) begin
            op = OP_RELEASE;
            if (held_ids.size() > 0 && $urandom_range(0, 1) == 1) begin
               pick = $urandom_range(0, held_ids.size() - 1);
               id   = held_ids[pick];
               held_ids.delete(pick);
            end else begin
               id = pick_id(full_range);
            end
         end else if (roll < 87) begin
            op = OP_QUERY;
            id = pick_id(full_range);
         end else if (roll < 90) begin
            op = OP_CLEAR;
         end else if (roll < 93) begin
            op = op_type'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
         end else begin
            // release or query of an id drawn from the whole id space
            op = ($urandom_range(0, 1) == 1) ? OP_RELEASE : OP_QUERY;
         end
         send_item(op, id);
      end
   endtask

   // ------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
   endtask

   task automatic check_reply();
      grant_reply_type want;
      if (expected_replies.size() == 0) begin
         report_mismatch("unexpected response", 32'(rsp_result_id), '0);
         return;
      end
      want = expected_replies.pop_front();
      if (rsp_result_id !== want.result_id)
         report_mismatch("result_id", 32'(rsp_result_id), 32'(want.result_id));
      if (rsp_in_use !== want.in_use)
         report_mismatch("in_use", 32'(rsp_in_use), 32'(want.in_use));
      if (rsp_status !== want.status)
         report_mismatch("status", 32'(rsp_status), 32'(want.status));
   endtask

   // draw a stall per response; honor a requested long hold
   initial begin : rsp_side
      int pause;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            pause = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            pause = steady ? 0 : $urandom_range(0, 10);
         end
         if (pause > 0) begin
            rsp_ready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         check_reply();
      end
   end

   // end the run when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   task automatic test_directed();
      // first allocate grows the empty pool and hands out id one
      send_item(OP_ALLOCATE, id_type'(ID_TOP));
      send_item(OP_CLAIM, '0);
      send_item(OP_CLAIM, 10'd5);
      send_item(OP_CLAIM, 10'd5);
      send_item(OP_CLAIM, 10'd20);
      // bad releases: id zero, id at the mark, top id
      send_item(OP_RELEASE, '0);
      send_item(OP_RELEASE, 10'd21);
      send_item(OP_RELEASE, id_type'(ID_TOP));
      send_item(OP_RELEASE, 10'd7);
      send_item(OP_RELEASE, 10'd1);
      send_item(OP_QUERY, '0);
      send_item(OP_QUERY, 10'd1);
      send_item(OP_QUERY, 10'd2);
      send_item(OP_QUERY, 10'd21);
      send_item(OP_QUERY, id_type'(ID_TOP));
      send_item(OP_SPARE_FIRST, id_type'(ID_TOP));
      send_item(op_type'(OP_SPARE_FIRST + 1), 10'h155);
      send_item(OP_SPARE_LAST, 10'h2AA);
      send_item(OP_CLEAR, id_type'(ID_TOP));
      send_item(OP_QUERY, 10'd3);
      send_item(OP_ALLOCATE, '0);
      // zero grow step: an empty pool cannot be refilled
      write_grow_step('0);
      send_item(OP_CLEAR, '0);
      send_item(OP_ALLOCATE, '0);
      send_item(OP_CLAIM, '0);
      write_grow_step('1);
      send_item(OP_ALLOCATE, '0);
   endtask

   // hold the response side off while requests keep coming
   task automatic test_backpressure();
      wait_idle();
      steady = 1'b1;
      hold_off_cycles = LONG_HOLD;
      random_items(40, 1'b0);
      steady = 1'b0;
   endtask

   task automatic test_random_steps();
      step_type phase_steps [5];
      phase_steps = '{7'd1, 7'd64, 7'd127, 7'd0, 7'd10};
      for (int p = 0; p < 5; p++) begin
         if (p == 3)
            write_grow_step(step_type'($urandom_range(2, 63)));
         else
            write_grow_step(phase_steps[p]);
         steady = (p == 2);
         random_items(120, 1'b0);
      end
      steady = 1'b0;
   endtask

   // grow the mark to the top of the id space and run it dry
   task automatic test_exhaustion();
      send_item(OP_CLAIM, id_type'(ID_TOP));
      send_item(OP_CLEAR, '0);
      send_item(OP_ALLOCATE, 10'h2AA);
      send_item(OP_CLAIM, '0);
      send_item(OP_RELEASE, id_type'(ID_TOP - 1));
      send_item(OP_ALLOCATE, '0);
      send_item(OP_ALLOCATE, 10'h155);
      write_grow_step(7'd64);
      random_items(180, 1'b1);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random_steps();
      test_exhaustion();
      wait_idle();
      if (mismatches == 0 && expected_replies.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
